// ===== rtl/delta_sample_channel_unit_macros.svh =====
// assertion macros for the delta sample channel unit
// used by the top level only, no other dependencies
`ifndef DELTA_SAMPLE_CHANNEL_UNIT_MACROS_SVH
`define DELTA_SAMPLE_CHANNEL_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, checked out of reset
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== rtl/dsc_pkg.sv =====
// shared types, constants and the rate table of the delta sample channel
// no dependencies
package dsc_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [15:0] AddrBase = 16'hC000;
  localparam logic [15:0] AddrWrap = 16'h8000;
  localparam logic [6:0]  LevelTop = 7'd125;

  // register write targets
  typedef enum logic [2:0] {
    REG_FLAGS  = 3'd0,
    REG_LEVEL  = 3'd1,
    REG_START  = 3'd2,
    REG_LENGTH = 3'd3,
    REG_ENABLE = 3'd4
  } reg_sel_e;

  // one input word
  typedef struct packed {
    logic       mode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] sample_byte;
  } dsc_item_t;

  // one result word
  typedef struct packed {
    logic [15:0] fetch_address;
    logic        fetch_used;
    logic        irq;
    logic [6:0]  output_level;
    logic        active;
  } dsc_result_t;

  // timer period per rate index, 0 ntsc and 1 pal
  function automatic logic [8:0] rate_lookup(input logic pal, input logic [3:0] idx);
    logic [8:0] ntsc_p;
    logic [8:0] pal_p;
    case (idx)
      4'd0:    begin ntsc_p = 9'd428; pal_p = 9'd398; end
      4'd1:    begin ntsc_p = 9'd380; pal_p = 9'd354; end
      4'd2:    begin ntsc_p = 9'd340; pal_p = 9'd316; end
      4'd3:    begin ntsc_p = 9'd320; pal_p = 9'd298; end
      4'd4:    begin ntsc_p = 9'd286; pal_p = 9'd276; end
      4'd5:    begin ntsc_p = 9'd254; pal_p = 9'd236; end
      4'd6:    begin ntsc_p = 9'd226; pal_p = 9'd210; end
      4'd7:    begin ntsc_p = 9'd214; pal_p = 9'd198; end
      4'd8:    begin ntsc_p = 9'd190; pal_p = 9'd176; end
      4'd9:    begin ntsc_p = 9'd160; pal_p = 9'd148; end
      4'd10:   begin ntsc_p = 9'd142; pal_p = 9'd132; end
      4'd11:   begin ntsc_p = 9'd128; pal_p = 9'd118; end
      4'd12:   begin ntsc_p = 9'd106; pal_p = 9'd98;  end
      4'd13:   begin ntsc_p = 9'd84;  pal_p = 9'd78;  end
      4'd14:   begin ntsc_p = 9'd72;  pal_p = 9'd66;  end
      default: begin ntsc_p = 9'd54;  pal_p = 9'd50;  end
    endcase
    return pal ? pal_p : ntsc_p;
  endfunction

  // first fetch address of a sample
  function automatic logic [15:0] start_addr(input logic [7:0] code);
    return AddrBase + {2'b00, code, 6'b000000};
  endfunction

  // byte count of a sample
  function automatic logic [11:0] sample_len(input logic [7:0] code);
    return {code, 4'b0000} + 12'd1;
  endfunction

endpackage

// ===== rtl/dsc_channel_core.sv =====
// channel state and its single-pass update for one word
// depends on dsc_pkg
module dsc_channel_core import dsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        step_i,
  input  dsc_item_t   item_i,
  output dsc_result_t result_o
);

  logic        video_std_q;
  logic        loop_q, loop_d;
  logic [8:0]  period_q, period_d;
  logic [7:0]  start_q, start_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] addr_q, addr_d;
  logic [11:0] left_q, left_d;
  logic [7:0]  buf_q, buf_d;
  logic        buf_empty_q, buf_empty_d;
  logic        playing_q, playing_d;
  logic [6:0]  level_q, level_d;
  logic [7:0]  shifter_q, shifter_d;
  logic [3:0]  bits_q, bits_d;
  logic [8:0]  timer_q, timer_d;
  logic        used, irq;

  // next state for a register write or a tick
  always_comb begin
    logic [15:0] addr_inc;
    logic [11:0] left_dec;
    logic [8:0]  timer_inc;
    addr_inc    = addr_q + 16'd1;
    left_dec    = left_q - 12'd1;
    timer_inc   = timer_q + 9'd1;
    loop_d      = loop_q;
    period_d    = period_q;
    start_d     = start_q;
    length_d    = length_q;
    addr_d      = addr_q;
    left_d      = left_q;
    buf_d       = buf_q;
    buf_empty_d = buf_empty_q;
    playing_d   = playing_q;
    level_d     = level_q;
    shifter_d   = shifter_q;
    bits_d      = bits_q;
    timer_d     = timer_q;
    used        = 1'b0;
    irq         = 1'b0;
    if (item_i.mode) begin
      case (item_i.reg_select)
        REG_FLAGS: begin
          loop_d   = item_i.write_data[6];
          period_d = rate_lookup(video_std_q, item_i.write_data[3:0]);
        end
        REG_LEVEL: begin
          level_d = item_i.write_data[6:0];
        end
        REG_START: begin
          start_d = item_i.write_data;
          addr_d  = start_addr(item_i.write_data);
        end
        REG_LENGTH: begin
          length_d = item_i.write_data;
          left_d   = sample_len(item_i.write_data);
        end
        REG_ENABLE: begin
          if (!item_i.write_data[0]) begin
            left_d = '0;
          end else if (left_q == '0) begin
            addr_d = start_addr(start_q);
            left_d = sample_len(length_q);
          end
        end
        default: ;
      endcase
    end else begin
      // fetcher: take the memory byte into an empty buffer
      if (buf_empty_q && left_q != '0) begin
        buf_d       = item_i.sample_byte;
        buf_empty_d = 1'b0;
        used        = 1'b1;
        left_d      = left_dec;
        if (left_dec == '0 && loop_q) begin
          addr_d = start_addr(start_q);
          left_d = sample_len(length_q);
        end else begin
          addr_d = (addr_inc == '0) ? AddrWrap : addr_inc;
          irq    = (left_dec == '0);
        end
      end
      // output unit runs while playing or holding a byte
      if (playing_q || !buf_empty_d) begin
        timer_d = timer_inc;
        if (timer_inc >= period_q) begin
          timer_d = '0;
          if (playing_q) begin
            if (shifter_q[0]) begin
              if (level_q <= LevelTop) level_d = level_q + 7'd2;
            end else if (level_q >= 7'd2) begin
              level_d = level_q - 7'd2;
            end
          end
          if (bits_q != '0) begin
            shifter_d = shifter_q >> 1;
            bits_d    = bits_q - 4'd1;
          end
        end
        // reload the shifter at the end of a byte
        if (bits_d == '0) begin
          bits_d = 4'd8;
          if (!buf_empty_d) begin
            shifter_d   = buf_d;
            playing_d   = 1'b1;
            buf_empty_d = 1'b1;
          end else begin
            playing_d = 1'b0;
          end
        end
      end
    end
  end

  // result word shows the state after this word
  always_comb begin
    result_o.fetch_address = addr_d;
    result_o.fetch_used    = used;
    result_o.irq           = irq;
    result_o.output_level  = level_d;
    result_o.active        = playing_d;
  end

  // video standard register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_std_q <= 1'b0;
    end else if (cfg_we_i) begin
      video_std_q <= cfg_wdata_i;
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q      <= 1'b0;
      period_q    <= '0;
      start_q     <= '0;
      length_q    <= '0;
      addr_q      <= '0;
      left_q      <= '0;
      buf_q       <= '0;
      buf_empty_q <= 1'b1;
      playing_q   <= 1'b0;
      level_q     <= '0;
      shifter_q   <= '0;
      bits_q      <= '0;
      timer_q     <= '0;
    end else if (step_i) begin
      loop_q      <= loop_d;
      period_q    <= period_d;
      start_q     <= start_d;
      length_q    <= length_d;
      addr_q      <= addr_d;
      left_q      <= left_d;
      buf_q       <= buf_d;
      buf_empty_q <= buf_empty_d;
      playing_q   <= playing_d;
      level_q     <= level_d;
      shifter_q   <= shifter_d;
      bits_q      <= bits_d;
      timer_q     <= timer_d;
    end
  end

endmodule

// ===== rtl/delta_sample_channel_unit.sv =====
// Delta sample channel: each input word is either one tick or one register write
// (tuser high), and each produces exactly one result word. A word is captured in an
// input register, passes the combinational channel update into an output register, and
// a new word can be taken every cycle unless the output stalls; the result word is
// offered from the output register. While a result waits there, the input register takes
// one more word and then holds tready low until the waiting result is taken.
// Depends on dsc_pkg, dsc_channel_core and delta_sample_channel_unit_macros.svh.
`include "delta_sample_channel_unit_macros.svh"

module delta_sample_channel_unit import dsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // reg_select[2:0], write_data[10:3], sample_byte[18:11], zero [23:19]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // mode: 0 tick, 1 register write
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // fetch_address[15:0], fetch_used[16], irq[17], output_level[24:18], active[25],
  // zero [31:26]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic        in_valid_q, in_valid_d;
  dsc_item_t   in_item_q;
  logic        out_valid_q, out_valid_d;
  dsc_result_t out_q;
  dsc_result_t core_res;
  logic        advance;
  logic        in_accept;

  // handshake control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d   = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.mode        <= s_axis_tuser;
      in_item_q.reg_select  <= s_axis_tdata[2:0];
      in_item_q.write_data  <= s_axis_tdata[10:3];
      in_item_q.sample_byte <= s_axis_tdata[18:11];
    end
  end

  // channel update
  dsc_channel_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (advance),
    .item_i     (in_item_q),
    .result_o   (core_res)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_q.active, out_q.output_level, out_q.irq,
                          out_q.fetch_used, out_q.fetch_address};

  // checks
  `DSC_ASSERT_IMPL(a_irq_needs_fetch, clk_i, rst_ni, out_valid_q && out_q.irq, out_q.fetch_used)
  `DSC_ASSERT_NEXT(a_write_no_fetch, clk_i, rst_ni, advance && in_item_q.mode, !out_q.fetch_used && !out_q.irq)
  `DSC_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)

endmodule
